// ----- rtl/core/i2c_slave_byte_controller_top_assert.svh -----
// ----------------------------------------------------------------------------
// i2c slave byte controller assertion macros
// concurrent checks clocked on i_clk, held off while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef I2C_SLAVE_BYTE_CONTROLLER_TOP_ASSERT_SVH
`define I2C_SLAVE_BYTE_CONTROLLER_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define I2CSBC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("i2c slave byte controller: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define I2CSBC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("i2c slave byte controller: next-cycle check failed");

`endif

// ----- rtl/core/i2csbc_pkg.sv -----
// ----------------------------------------------------------------------------
// i2csbc_pkg
// shared types and constants of the i2c slave byte controller
// ----------------------------------------------------------------------------
`default_nettype none

package i2csbc_pkg;

    localparam int unsigned RX_DEPTH = 16;
    localparam int unsigned TX_DEPTH = 16;
    localparam int unsigned RX_IDX_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int unsigned TX_IDX_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

    localparam int unsigned ADDR_W  = 7;
    localparam int unsigned LEVEL_W = 8;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
    localparam logic [7:0] RW_BIT = 8'h01;

    typedef enum logic [2:0] {
        CMD_START = 3'd0,
        CMD_SHIFT = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_PUT   = 3'd3,
        CMD_GET   = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ACT_NONE        = 3'd0,
        ACT_DRIVE_ACK   = 3'd1,
        ACT_SEND        = 3'd2,
        ACT_SAMPLE_ACK  = 3'd3,
        ACT_SAMPLE_BYTE = 3'd4,
        ACT_RELEASE     = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        PH_CHECK_ADDR  = 3'd0,
        PH_SEND        = 3'd1,
        PH_REQ_REPLY   = 3'd2,
        PH_CHECK_REPLY = 3'd3,
        PH_REQ_DATA    = 3'd4,
        PH_GET_DATA    = 3'd5
    } t_phase;

    typedef struct packed {
        t_cmd       command;
        logic       start_completed;
        logic [7:0] bus_byte;
        logic [7:0] host_byte;
    } t_in_beat;

    typedef struct packed {
        t_action            line_action;
        logic [7:0]         shift_out_byte;
        logic               transmit_request;
        logic               receive_done;
        logic [LEVEL_W-1:0] received_count;
        logic [7:0]         rx_data;
        logic               rx_empty;
        logic               tx_accepted;
        logic [LEVEL_W-1:0] rx_available;
        logic               bus_busy;
    } t_out_beat;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] data;
    } t_rx_op;

    typedef struct packed {
        logic               empty;
        logic [LEVEL_W-1:0] level;
        logic [7:0]         pop_data;
    } t_rx_stat;

    typedef struct packed {
        logic       put;
        logic       take;
        logic       clear;
        logic [7:0] data;
    } t_tx_op;

    typedef struct packed {
        logic       empty;
        logic       full;
        logic [7:0] take_data;
    } t_tx_stat;

endpackage

`default_nettype wire

// ----- rtl/core/i2csbc_rx_ring.sv -----
// ----------------------------------------------------------------------------
// i2csbc_rx_ring
// receive ring: head advanced before write, overwrites when full, level count
// ----------------------------------------------------------------------------
`default_nettype none

module i2csbc_rx_ring (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire i2csbc_pkg::t_rx_op    i_op,
    output i2csbc_pkg::t_rx_stat       o_stat
);

    localparam int unsigned IdxW = i2csbc_pkg::RX_IDX_W;
    localparam logic [IdxW-1:0] LastIdx = IdxW'(i2csbc_pkg::RX_DEPTH - 1);

    logic [7:0]      r_store [i2csbc_pkg::RX_DEPTH];
    logic [IdxW-1:0] r_head;
    logic [IdxW-1:0] r_tail;
    logic [i2csbc_pkg::LEVEL_W-1:0] r_level;

    logic [IdxW-1:0] head_inc;
    logic [IdxW-1:0] tail_inc;

    assign head_inc = (r_head == LastIdx) ? '0 : r_head + 1'b1;
    assign tail_inc = (r_tail == LastIdx) ? '0 : r_tail + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_op.push) begin
            r_store[head_inc] <= i_op.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_level <= '0;
        end else if (i_op.push) begin
            r_head <= head_inc;
            if (r_level != i2csbc_pkg::LEVEL_MAX) begin
                r_level <= r_level + 1'b1;
            end
        end else if (i_op.pop) begin
            r_tail <= tail_inc;
            if (r_level != '0) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

    assign o_stat.empty    = (r_head == r_tail);
    assign o_stat.level    = r_level;
    assign o_stat.pop_data = r_store[tail_inc];

endmodule

`default_nettype wire

// ----- rtl/core/i2csbc_tx_ring.sv -----
// ----------------------------------------------------------------------------
// i2csbc_tx_ring
// transmit ring: host puts, bus takes, a master nack clears it
// ----------------------------------------------------------------------------
`default_nettype none

module i2csbc_tx_ring (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire i2csbc_pkg::t_tx_op    i_op,
    output i2csbc_pkg::t_tx_stat       o_stat
);

    localparam int unsigned IdxW = i2csbc_pkg::TX_IDX_W;
    localparam logic [IdxW-1:0] LastIdx = IdxW'(i2csbc_pkg::TX_DEPTH - 1);

    logic [7:0]      r_store [i2csbc_pkg::TX_DEPTH];
    logic [IdxW-1:0] r_head;
    logic [IdxW-1:0] r_tail;

    logic [IdxW-1:0] head_inc;
    logic [IdxW-1:0] tail_inc;

    assign head_inc = (r_head == LastIdx) ? '0 : r_head + 1'b1;
    assign tail_inc = (r_tail == LastIdx) ? '0 : r_tail + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_op.put) begin
            r_store[head_inc] <= i_op.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
        end else if (i_op.clear) begin
            r_head <= '0;
            r_tail <= '0;
        end else if (i_op.put) begin
            r_head <= head_inc;
        end else if (i_op.take) begin
            r_tail <= tail_inc;
        end
    end

    assign o_stat.empty     = (r_head == r_tail);
    assign o_stat.full      = (head_inc == r_tail);
    assign o_stat.take_data = r_store[tail_inc];

endmodule

`default_nettype wire

// ----- rtl/core/i2csbc_ctrl.sv -----
// ----------------------------------------------------------------------------
// i2csbc_ctrl
// protocol sequencer: address match, read/write paths, ring operations
// ----------------------------------------------------------------------------
`default_nettype none

module i2csbc_ctrl (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_fire,
    input  wire i2csbc_pkg::t_in_beat               i_item,
    input  wire logic [i2csbc_pkg::ADDR_W-1:0]      i_own_address,
    input  wire i2csbc_pkg::t_rx_stat               i_rx_stat,
    input  wire i2csbc_pkg::t_tx_stat               i_tx_stat,
    output i2csbc_pkg::t_rx_op                      o_rx_op,
    output i2csbc_pkg::t_tx_op                      o_tx_op,
    output i2csbc_pkg::t_out_beat                   o_result
);

    i2csbc_pkg::t_phase r_phase, n_phase;
    logic r_listening, n_listening;
    logic r_receiving, n_receiving;
    logic r_busy, n_busy;

    logic shifting;
    logic addr_match;
    logic read_req;
    logic nack;
    logic send_now;
    logic send_ok;

    assign shifting   = i_fire && (i_item.command == i2csbc_pkg::CMD_SHIFT) && r_listening;
    assign addr_match = (i_item.bus_byte == 8'h00) ||
                        (i_item.bus_byte[7:1] == i_own_address);
    assign read_req   = (i_item.bus_byte & i2csbc_pkg::RW_BIT) != 8'h00;
    assign nack       = (i_item.bus_byte != 8'h00);
    assign send_now   = shifting && ((r_phase == i2csbc_pkg::PH_SEND) ||
                        ((r_phase == i2csbc_pkg::PH_CHECK_REPLY) && !nack));
    assign send_ok    = send_now && !i_tx_stat.empty;

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_listening = r_listening;
        n_receiving = r_receiving;
        n_busy      = r_busy;
        if (i_fire) begin
            case (i_item.command)
                i2csbc_pkg::CMD_START: begin
                    n_busy  = 1'b1;
                    n_phase = i2csbc_pkg::PH_CHECK_ADDR;
                    if (i_item.start_completed) begin
                        n_listening = 1'b1;
                        n_receiving = 1'b0;
                    end
                end
                i2csbc_pkg::CMD_SHIFT: begin
                    if (r_listening) begin
                        case (r_phase)
                            i2csbc_pkg::PH_CHECK_ADDR: begin
                                if (!addr_match) begin
                                    n_listening = 1'b0;
                                end else if (read_req) begin
                                    n_phase = i2csbc_pkg::PH_SEND;
                                end else begin
                                    n_receiving = 1'b1;
                                    n_phase     = i2csbc_pkg::PH_REQ_DATA;
                                end
                            end
                            i2csbc_pkg::PH_CHECK_REPLY: begin
                                if (nack) begin
                                    n_listening = 1'b0;
                                end
                            end
                            i2csbc_pkg::PH_REQ_REPLY: begin
                                n_phase = i2csbc_pkg::PH_CHECK_REPLY;
                            end
                            i2csbc_pkg::PH_REQ_DATA: begin
                                n_phase = i2csbc_pkg::PH_GET_DATA;
                            end
                            i2csbc_pkg::PH_GET_DATA: begin
                                n_phase = i2csbc_pkg::PH_REQ_DATA;
                            end
                            default: begin
                            end
                        endcase
                        if (send_now) begin
                            if (send_ok) begin
                                n_phase = i2csbc_pkg::PH_REQ_REPLY;
                            end else begin
                                n_listening = 1'b0;
                            end
                        end
                    end
                end
                i2csbc_pkg::CMD_STOP: begin
                    n_busy      = 1'b0;
                    n_receiving = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // outputs and ring operations
    always_comb begin
        o_rx_op  = '0;
        o_tx_op  = '0;
        o_result = '0;
        o_rx_op.data = i_item.bus_byte;
        o_tx_op.data = i_item.host_byte;
        o_result.line_action = i2csbc_pkg::ACT_NONE;
        if (i_fire) begin
            case (i_item.command)
                i2csbc_pkg::CMD_START: begin
                    if (i_item.start_completed) begin
                        o_result.line_action = i2csbc_pkg::ACT_SAMPLE_BYTE;
                        if (r_receiving) begin
                            o_result.receive_done   = 1'b1;
                            o_result.received_count = i_rx_stat.level;
                        end
                    end
                end
                i2csbc_pkg::CMD_SHIFT: begin
                    if (r_listening) begin
                        case (r_phase)
                            i2csbc_pkg::PH_CHECK_ADDR: begin
                                if (addr_match) begin
                                    o_result.line_action      = i2csbc_pkg::ACT_DRIVE_ACK;
                                    o_result.transmit_request = read_req;
                                end else begin
                                    o_result.line_action = i2csbc_pkg::ACT_RELEASE;
                                end
                            end
                            i2csbc_pkg::PH_CHECK_REPLY: begin
                                if (nack) begin
                                    o_result.line_action = i2csbc_pkg::ACT_RELEASE;
                                    o_tx_op.clear        = 1'b1;
                                end
                            end
                            i2csbc_pkg::PH_REQ_REPLY: begin
                                o_result.line_action = i2csbc_pkg::ACT_SAMPLE_ACK;
                            end
                            i2csbc_pkg::PH_REQ_DATA: begin
                                o_result.line_action = i2csbc_pkg::ACT_SAMPLE_BYTE;
                            end
                            i2csbc_pkg::PH_GET_DATA: begin
                                o_result.line_action = i2csbc_pkg::ACT_DRIVE_ACK;
                                o_rx_op.push         = 1'b1;
                            end
                            default: begin
                            end
                        endcase
                        if (send_now) begin
                            if (send_ok) begin
                                o_result.line_action    = i2csbc_pkg::ACT_SEND;
                                o_result.shift_out_byte = i_tx_stat.take_data;
                                o_tx_op.take            = 1'b1;
                            end else begin
                                o_result.line_action = i2csbc_pkg::ACT_RELEASE;
                            end
                        end
                    end
                end
                i2csbc_pkg::CMD_STOP: begin
                    if (r_receiving && (i_rx_stat.level != '0)) begin
                        o_result.receive_done   = 1'b1;
                        o_result.received_count = i_rx_stat.level;
                    end
                end
                i2csbc_pkg::CMD_PUT: begin
                    if (!i_tx_stat.full) begin
                        o_tx_op.put          = 1'b1;
                        o_result.tx_accepted = 1'b1;
                    end
                end
                i2csbc_pkg::CMD_GET: begin
                    if (i_rx_stat.empty) begin
                        o_result.rx_empty = 1'b1;
                    end else begin
                        o_rx_op.pop      = 1'b1;
                        o_result.rx_data = i_rx_stat.pop_data;
                    end
                end
                default: begin
                end
            endcase
        end
        // level as it stands after this event
        o_result.rx_available = i_rx_stat.level;
        if (o_rx_op.push && (i_rx_stat.level != i2csbc_pkg::LEVEL_MAX)) begin
            o_result.rx_available = i_rx_stat.level + 1'b1;
        end else if (o_rx_op.pop && (i_rx_stat.level != '0)) begin
            o_result.rx_available = i_rx_stat.level - 1'b1;
        end
        o_result.bus_busy = n_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= i2csbc_pkg::PH_CHECK_ADDR;
            r_listening <= 1'b0;
            r_receiving <= 1'b0;
            r_busy      <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_listening <= n_listening;
            r_receiving <= n_receiving;
            r_busy      <= n_busy;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/i2c_slave_byte_controller_top.sv -----
// ----------------------------------------------------------------------------
// i2c_slave_byte_controller_top
// byte-level i2c slave engine with 16-entry receive and transmit rings
// ----------------------------------------------------------------------------
// The block takes one event beat per clock (start, finished shift, stop,
// host put, host get) and returns exactly one result beat for each. A beat
// is captured in an input register, the protocol sequencer and both rings
// update in one pass of logic, and the result lands in an output register
// that drives o_out_valid; sustained throughput is one beat per cycle, and
// only a stalled output register holds off new beats. The rings are
// flip-flop arrays of 16 bytes, each holding up to 15 bytes; a full receive
// ring is overwritten and its level saturates at 255. own_address sits at
// byte address 0 of the register port.
`default_nettype none
`include "i2c_slave_byte_controller_top_assert.svh"

module i2c_slave_byte_controller_top (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // event channel
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire i2csbc_pkg::t_in_beat   i_in_data,
    // result channel
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output i2csbc_pkg::t_out_beat       o_out_data,
    // register port
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [2:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    // register index taken from the word address bit
    localparam logic RegOwnAddress = 1'b0;

    logic [i2csbc_pkg::ADDR_W-1:0] r_own_address;

    logic                  r_in_valid;
    i2csbc_pkg::t_in_beat  r_in_beat;
    logic                  r_out_valid;
    i2csbc_pkg::t_out_beat r_out_beat;

    logic in_take;     // input beat accepted this edge
    logic advance;     // held beat is processed this edge
    logic cfg_write;

    i2csbc_pkg::t_rx_op    rx_op;
    i2csbc_pkg::t_rx_stat  rx_stat;
    i2csbc_pkg::t_tx_op    tx_op;
    i2csbc_pkg::t_tx_stat  tx_stat;
    i2csbc_pkg::t_out_beat result;

    // ---------------------------------------------------------------- regs
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == RegOwnAddress);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address <= '0;
        end else if (cfg_write) begin
            r_own_address <= pwdata[i2csbc_pkg::ADDR_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == RegOwnAddress) begin
            prdata = {{(32 - i2csbc_pkg::ADDR_W){1'b0}}, r_own_address};
        end
    end

    // ---------------------------------------------------------------- flow
    // the held beat moves on whenever the result register is free or draining
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_take || (r_in_valid && !advance);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_beat <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_beat <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_beat;

    // ---------------------------------------------------------------- core
    i2csbc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (advance),
        .i_item        (r_in_beat),
        .i_own_address (r_own_address),
        .i_rx_stat     (rx_stat),
        .i_tx_stat     (tx_stat),
        .o_rx_op       (rx_op),
        .o_tx_op       (tx_op),
        .o_result      (result)
    );

    i2csbc_rx_ring u_rx_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (rx_op),
        .o_stat  (rx_stat)
    );

    i2csbc_tx_ring u_tx_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (tx_op),
        .o_stat  (tx_stat)
    );

    // ---------------------------------------------------------------- checks
    // a held beat that did not move on is still held next cycle
    `I2CSBC_ASSERT_NEXT(a_hold_in_beat, r_in_valid && !advance, r_in_valid)
    // input stall only while both registers are occupied
    `I2CSBC_ASSERT_SAME(a_stall_cause, o_in_stall, r_in_valid && r_out_valid && i_out_stall)
    // a stored host byte never comes with a line action or end of reception
    `I2CSBC_ASSERT_SAME(a_put_quiet, o_out_valid && o_out_data.tx_accepted, (o_out_data.line_action == i2csbc_pkg::ACT_NONE) && !o_out_data.receive_done)
    // end of reception is only reported on start or stop beats
    `I2CSBC_ASSERT_SAME(a_done_action, o_out_valid && o_out_data.receive_done, (o_out_data.line_action == i2csbc_pkg::ACT_NONE) || (o_out_data.line_action == i2csbc_pkg::ACT_SAMPLE_BYTE))

endmodule

`default_nettype wire
